// File: rtl/htlp_pkg.sv
`timescale 1ns / 1ps

package htlp_pkg;

    localparam int SLOT_COUNT      = 1024;
    localparam int SLOT_W          = $clog2(SLOT_COUNT);
    localparam int ADDR_W          = SLOT_W + 1;
    localparam int BANK_DEPTH      = 2 * SLOT_COUNT;
    localparam int REBUILD_DIVISOR = 8;
    localparam int REBUILD_LIMIT   = SLOT_COUNT / REBUILD_DIVISOR;

    localparam int KIND_W     = 3;
    localparam int KEY_W      = 64;
    localparam int HANDLE_W   = 32;
    localparam int TARGET_W   = 10;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 11;
    localparam int CFG_W      = 10;
    localparam int CNT_W      = 11;
    localparam int MARK_W     = 2;
    localparam int WORD_W     = MARK_W + KEY_W + HANDLE_W;

    localparam logic [CNT_W-1:0]      LIVE_CAP   = 11'd2047;
    localparam logic [CNT_W-1:0]      PROBE_LAST = CNT_W'(SLOT_COUNT - 1);
    localparam logic [SLOT_W-1:0]     SLOT_LAST  = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [SLOT_OUT_W-1:0] SLOT_NONE  = 11'd1024;
    localparam logic [CFG_W-1:0]      MAX_RESET  = 10'd512;

    localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
    localparam logic [MARK_W-1:0] MARK_OCC   = 2'd1;
    localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FIND    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ERASE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RESERVE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_COMMIT  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ID  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT = 3'd5;

    // splitmix64 finalizer constants
    localparam logic [KEY_W-1:0] HASH_C0 = 64'h9e3779b97f4a7c15;
    localparam logic [KEY_W-1:0] HASH_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [KEY_W-1:0] HASH_C2 = 64'h94d049bb133111eb;
    localparam int HASH_S1 = 30;
    localparam int HASH_S2 = 27;
    localparam int HASH_S3 = 31;

endpackage

// File: rtl/htlp_in_if.sv
`timescale 1ns / 1ps

interface htlp_in_if;
    logic                           valid;
    logic                           ready;
    logic [htlp_pkg::KIND_W-1:0]    kind;
    logic [htlp_pkg::KEY_W-1:0]     order_key;
    logic [htlp_pkg::HANDLE_W-1:0]  order_handle;
    logic [htlp_pkg::TARGET_W-1:0]  target_slot;

    modport source (output valid, kind, order_key, order_handle, target_slot, input ready);
    modport sink   (input valid, kind, order_key, order_handle, target_slot, output ready);
endinterface

// File: rtl/htlp_out_if.sv
`timescale 1ns / 1ps

interface htlp_out_if;
    logic                             valid;
    logic                             ready;
    logic [htlp_pkg::STATUS_W-1:0]    status;
    logic [htlp_pkg::HANDLE_W-1:0]    found_handle;
    logic [htlp_pkg::SLOT_OUT_W-1:0]  slot_index;

    modport source (output valid, status, found_handle, slot_index, input ready);
    modport sink   (input valid, status, found_handle, slot_index, output ready);
endinterface

// File: rtl/htlp_ram.sv
`timescale 1ns / 1ps

module htlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/hash_table_linear_probe_tombstone_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Modport  Beat
// req       in   sink     kind, order_key, order_handle, target_slot
// rsp       out  source   status, found_handle, slot_index
// cfg       in   -        cfg_we / cfg_wdata -> max_entries
//
// Ops: a walk hashes the key on one shared 32x32 multiplier (64-bit products
//   from low and cross partial products), then probes: a RAM read state,
//   then a check state, per slot. Commit reads and writes the target slot.
// Rebuild (tombstones > SLOT_COUNT/REBUILD_DIVISOR): clears the spare bank,
//   reads each source slot, then hashes and probes each live entry into it.
// Reset: a sweep clears the marks of bank 0; req.ready stays low meanwhile.
// One op in flight; a finished beat waits in the rsp register while the
//   next op is accepted.

module hash_table_linear_probe_tombstone_top (
    input  logic                        clk,
    input  logic                        rst_n,
    htlp_in_if.sink                     req,
    htlp_out_if.source                  rsp,
    input  logic                        cfg_we,
    input  logic [htlp_pkg::CFG_W-1:0]  cfg_wdata
);

    localparam int SW = htlp_pkg::SLOT_W;
    localparam int AW = htlp_pkg::ADDR_W;
    localparam int KW = htlp_pkg::KEY_W;
    localparam int HW = htlp_pkg::HANDLE_W;
    localparam int CW = htlp_pkg::CNT_W;
    localparam int OW = htlp_pkg::SLOT_OUT_W;
    localparam int TW = htlp_pkg::STATUS_W;

    localparam logic [3:0] S_INIT_CLR = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_HASH     = 4'd2;
    localparam logic [3:0] S_PRB_RD   = 4'd3;
    localparam logic [3:0] S_PRB_CHK  = 4'd4;
    localparam logic [3:0] S_CMT_RD   = 4'd5;
    localparam logic [3:0] S_CMT_CHK  = 4'd6;
    localparam logic [3:0] S_RB_CLR   = 4'd7;
    localparam logic [3:0] S_RB_RD    = 4'd8;
    localparam logic [3:0] S_RB_CHK   = 4'd9;
    localparam logic [3:0] S_RB_PRD   = 4'd10;
    localparam logic [3:0] S_RB_PCHK  = 4'd11;
    localparam logic [3:0] S_RESP     = 4'd12;

    localparam logic [3:0] H_LAST = 4'd10;

    // control
    logic [3:0]    state_reg, state_next;
    logic          bank_reg, bank_next;
    logic [CW-1:0] live_reg, live_next;
    logic [CW-1:0] tomb_reg, tomb_next;
    logic [htlp_pkg::CFG_W-1:0] max_reg, max_next;
    logic [CW-1:0] n_reg, n_next;
    logic [SW-1:0] rb_idx_reg, rb_idx_next;
    logic          rb_mode_reg, rb_mode_next;
    logic [3:0]    h_cnt_reg, h_cnt_next;
    logic          out_valid_reg, out_valid_next;

    // payload
    logic [htlp_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [KW-1:0]                 key_reg, key_next;
    logic [HW-1:0]                 handle_reg, handle_next;
    logic [htlp_pkg::TARGET_W-1:0] target_reg, target_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [OW-1:0] tslot_reg, tslot_next;
    logic [KW-1:0] h_v_reg, h_v_next;
    logic [KW-1:0] h_acc_reg, h_acc_next;
    logic [KW-1:0] h_prod_reg, h_prod_next;
    logic [KW-1:0] src_key_reg, src_key_next;
    logic [HW-1:0] src_handle_reg, src_handle_next;
    logic [TW-1:0] res_status_reg, res_status_next;
    logic [HW-1:0] res_handle_reg, res_handle_next;
    logic [OW-1:0] res_slot_reg, res_slot_next;
    logic [TW-1:0] out_status_reg, out_status_next;
    logic [HW-1:0] out_handle_reg, out_handle_next;
    logic [OW-1:0] out_slot_reg, out_slot_next;

    // memory port
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [htlp_pkg::WORD_W-1:0] mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [htlp_pkg::WORD_W-1:0] mem_rdata;

    logic [htlp_pkg::MARK_W-1:0] rd_mark;
    logic [KW-1:0]               rd_key;
    logic [HW-1:0]               rd_handle;

    assign rd_mark   = mem_rdata[htlp_pkg::WORD_W-1 -: htlp_pkg::MARK_W];
    assign rd_key    = mem_rdata[HW +: KW];
    assign rd_handle = mem_rdata[HW-1:0];

    htlp_ram #(
        .WIDTH (htlp_pkg::WORD_W),
        .DEPTH (htlp_pkg::BANK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // hash datapath: one 32x32 multiplier, operand halves picked by step
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [KW-1:0] mul_c;
    logic [SW-1:0] home;

    always_comb
    begin
        mul_c = (h_cnt_reg < 4'd5) ? htlp_pkg::HASH_C1 : htlp_pkg::HASH_C2;
        mul_a = h_v_reg[31:0];
        mul_b = mul_c[31:0];
        case (h_cnt_reg)
            4'd2, 4'd7:
            begin
                mul_a = h_v_reg[63:32];
            end
            4'd3, 4'd8:
            begin
                mul_b = mul_c[63:32];
            end
            default:
            begin
                mul_a = h_v_reg[31:0];
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    assign home = h_v_reg[SW-1:0] ^ h_v_reg[htlp_pkg::HASH_S3 +: SW];

    // probe decisions
    logic          match;
    logic          last_probe;
    logic [SW-1:0] slot_inc;
    logic [OW-1:0] tomb_new;
    logic [OW-1:0] dest;
    logic          live_full;
    logic          rb_due;
    logic [CW-1:0] live_inc;
    logic [CW-1:0] tomb_dec;

    always_comb
    begin
        match      = (rd_mark == htlp_pkg::MARK_OCC) && (rd_key == key_reg);
        last_probe = (n_reg == htlp_pkg::PROBE_LAST);
        slot_inc   = slot_reg + 1'b1;
        tomb_new   = ((rd_mark == htlp_pkg::MARK_TOMB) && (tslot_reg == htlp_pkg::SLOT_NONE))
                     ? {1'b0, slot_reg} : tslot_reg;
        if ((rd_mark == htlp_pkg::MARK_EMPTY) && (tomb_new == htlp_pkg::SLOT_NONE))
        begin
            dest = {1'b0, slot_reg};
        end
        else
        begin
            dest = tomb_new;
        end
        live_full = (live_reg >= {1'b0, max_reg});
        rb_due    = (tomb_reg > CW'(htlp_pkg::REBUILD_LIMIT));
        live_inc  = (live_reg < htlp_pkg::LIVE_CAP) ? live_reg + 1'b1 : live_reg;
        tomb_dec  = (tomb_reg != '0) ? tomb_reg - 1'b1 : tomb_reg;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.found_handle = out_handle_reg;
    assign rsp.slot_index   = out_slot_reg;

    always_comb
    begin
        state_next      = state_reg;
        bank_next       = bank_reg;
        live_next       = live_reg;
        tomb_next       = tomb_reg;
        max_next        = cfg_we ? cfg_wdata : max_reg;
        n_next          = n_reg;
        rb_idx_next     = rb_idx_reg;
        rb_mode_next    = rb_mode_reg;
        h_cnt_next      = h_cnt_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        handle_next     = handle_reg;
        target_next     = target_reg;
        slot_next       = slot_reg;
        tslot_next      = tslot_reg;
        h_v_next        = h_v_reg;
        h_acc_next      = h_acc_reg;
        h_prod_next     = h_prod_reg;
        src_key_next    = src_key_reg;
        src_handle_next = src_handle_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;
        out_slot_next   = out_slot_reg;
        mem_we          = 1'b0;
        mem_waddr       = {bank_reg, slot_reg};
        mem_wdata       = {htlp_pkg::MARK_OCC, key_reg, handle_reg};
        mem_raddr       = {bank_reg, slot_reg};

        case (state_reg)
            S_INIT_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = {bank_reg, n_reg[SW-1:0]};
                mem_wdata = {htlp_pkg::MARK_EMPTY, {KW{1'b0}}, {HW{1'b0}}};
                n_next    = n_reg + 1'b1;
                if (last_probe)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next       = req.kind;
                    key_next        = req.order_key;
                    handle_next     = req.order_handle;
                    target_next     = req.target_slot;
                    res_status_next = htlp_pkg::ST_DONE;
                    res_handle_next = '0;
                    res_slot_next   = htlp_pkg::SLOT_NONE;
                    h_v_next        = req.order_key + htlp_pkg::HASH_C0;
                    h_cnt_next      = '0;
                    rb_mode_next    = 1'b0;
                    n_next          = '0;
                    case (req.kind)
                        htlp_pkg::KIND_INSERT:
                        begin
                            if (req.order_key == '0)
                            begin
                                res_status_next = htlp_pkg::ST_BAD_ID;
                                state_next      = S_RESP;
                            end
                            else if (live_full)
                            begin
                                res_status_next = htlp_pkg::ST_FULL;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = rb_due ? S_RB_CLR : S_HASH;
                            end
                        end
                        htlp_pkg::KIND_FIND, htlp_pkg::KIND_ERASE:
                        begin
                            if (req.order_key == '0)
                            begin
                                res_status_next = htlp_pkg::ST_BAD_ID;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_HASH;
                            end
                        end
                        htlp_pkg::KIND_RESERVE:
                        begin
                            state_next = rb_due ? S_RB_CLR : S_HASH;
                        end
                        htlp_pkg::KIND_COMMIT:
                        begin
                            if ({1'b0, req.target_slot} >= OW'(htlp_pkg::SLOT_COUNT))
                            begin
                                res_status_next = htlp_pkg::ST_NO_SLOT;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_CMT_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_HASH:
            begin
                h_cnt_next  = h_cnt_reg + 1'b1;
                h_prod_next = mul_p;
                case (h_cnt_reg)
                    4'd0:
                    begin
                        h_v_next = h_v_reg ^ (h_v_reg >> htlp_pkg::HASH_S1);
                    end
                    4'd2, 4'd7:
                    begin
                        h_acc_next = h_prod_reg;
                    end
                    4'd3, 4'd8:
                    begin
                        h_acc_next = h_acc_reg + {h_prod_reg[31:0], 32'd0};
                    end
                    4'd4, 4'd9:
                    begin
                        h_v_next = h_acc_reg + {h_prod_reg[31:0], 32'd0};
                    end
                    4'd5:
                    begin
                        h_v_next = h_v_reg ^ (h_v_reg >> htlp_pkg::HASH_S2);
                    end
                    H_LAST:
                    begin
                        slot_next  = home;
                        n_next     = '0;
                        tslot_next = htlp_pkg::SLOT_NONE;
                        state_next = rb_mode_reg ? S_RB_PRD : S_PRB_RD;
                    end
                    default:
                    begin
                        h_acc_next = h_acc_reg;
                    end
                endcase
            end

            S_PRB_RD:
            begin
                mem_raddr  = {bank_reg, slot_reg};
                state_next = S_PRB_CHK;
            end

            S_PRB_CHK:
            begin
                if ((kind_reg == htlp_pkg::KIND_FIND) || (kind_reg == htlp_pkg::KIND_ERASE))
                begin
                    if (rd_mark == htlp_pkg::MARK_EMPTY)
                    begin
                        res_status_next = htlp_pkg::ST_ABSENT;
                        state_next      = S_RESP;
                    end
                    else if (match)
                    begin
                        if (kind_reg == htlp_pkg::KIND_FIND)
                        begin
                            res_handle_next = rd_handle;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = {bank_reg, slot_reg};
                            mem_wdata = {htlp_pkg::MARK_TOMB, rd_key, rd_handle};
                            live_next = (live_reg != '0) ? live_reg - 1'b1 : live_reg;
                            tomb_next = tomb_reg + 1'b1;
                        end
                        state_next = S_RESP;
                    end
                    else if (last_probe)
                    begin
                        res_status_next = htlp_pkg::ST_ABSENT;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        slot_next  = slot_inc;
                        n_next     = n_reg + 1'b1;
                        state_next = S_PRB_RD;
                    end
                end
                else
                begin
                    // insert or reserve: first tombstone wins over the ending empty slot
                    if (match)
                    begin
                        res_status_next = htlp_pkg::ST_PRESENT;
                        if (kind_reg == htlp_pkg::KIND_RESERVE)
                        begin
                            res_slot_next = {1'b0, slot_reg};
                        end
                        state_next = S_RESP;
                    end
                    else if ((rd_mark == htlp_pkg::MARK_EMPTY) || last_probe)
                    begin
                        if (dest == htlp_pkg::SLOT_NONE)
                        begin
                            res_status_next = htlp_pkg::ST_NO_SLOT;
                        end
                        else if (kind_reg == htlp_pkg::KIND_RESERVE)
                        begin
                            res_slot_next = dest;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = {bank_reg, dest[SW-1:0]};
                            mem_wdata = {htlp_pkg::MARK_OCC, key_reg, handle_reg};
                            live_next = live_inc;
                            if (tomb_new != htlp_pkg::SLOT_NONE)
                            begin
                                tomb_next = tomb_dec;
                            end
                        end
                        state_next = S_RESP;
                    end
                    else
                    begin
                        tslot_next = tomb_new;
                        slot_next  = slot_inc;
                        n_next     = n_reg + 1'b1;
                        state_next = S_PRB_RD;
                    end
                end
            end

            S_CMT_RD:
            begin
                mem_raddr  = {bank_reg, target_reg[SW-1:0]};
                state_next = S_CMT_CHK;
            end

            S_CMT_CHK:
            begin
                mem_we    = 1'b1;
                mem_waddr = {bank_reg, target_reg[SW-1:0]};
                mem_wdata = {htlp_pkg::MARK_OCC, key_reg, handle_reg};
                live_next = live_inc;
                if (rd_mark == htlp_pkg::MARK_TOMB)
                begin
                    tomb_next = tomb_dec;
                end
                state_next = S_RESP;
            end

            S_RB_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = {~bank_reg, n_reg[SW-1:0]};
                mem_wdata = {htlp_pkg::MARK_EMPTY, {KW{1'b0}}, {HW{1'b0}}};
                n_next    = n_reg + 1'b1;
                if (last_probe)
                begin
                    rb_idx_next = '0;
                    state_next  = S_RB_RD;
                end
            end

            S_RB_RD:
            begin
                mem_raddr  = {bank_reg, rb_idx_reg};
                state_next = S_RB_CHK;
            end

            S_RB_CHK, S_RB_PCHK:
            begin
                if ((state_reg == S_RB_CHK) && (rd_mark == htlp_pkg::MARK_OCC))
                begin
                    src_key_next    = rd_key;
                    src_handle_next = rd_handle;
                    h_v_next        = rd_key + htlp_pkg::HASH_C0;
                    h_cnt_next      = '0;
                    rb_mode_next    = 1'b1;
                    state_next      = S_HASH;
                end
                else if ((state_reg == S_RB_PCHK) && (rd_mark == htlp_pkg::MARK_OCC)
                         && !last_probe)
                begin
                    slot_next  = slot_inc;
                    n_next     = n_reg + 1'b1;
                    state_next = S_RB_PRD;
                end
                else
                begin
                    if (state_reg == S_RB_PCHK)
                    begin
                        // full walk lands back on the home slot
                        mem_we    = 1'b1;
                        mem_waddr = {~bank_reg,
                                     (rd_mark != htlp_pkg::MARK_OCC) ? slot_reg : slot_inc};
                        mem_wdata = {htlp_pkg::MARK_OCC, src_key_reg, src_handle_reg};
                    end
                    if (rb_idx_reg == htlp_pkg::SLOT_LAST)
                    begin
                        bank_next    = ~bank_reg;
                        tomb_next    = '0;
                        h_v_next     = key_reg + htlp_pkg::HASH_C0;
                        h_cnt_next   = '0;
                        rb_mode_next = 1'b0;
                        state_next   = S_HASH;
                    end
                    else
                    begin
                        rb_idx_next = rb_idx_reg + 1'b1;
                        state_next  = S_RB_RD;
                    end
                end
            end

            S_RB_PRD:
            begin
                mem_raddr  = {~bank_reg, slot_reg};
                state_next = S_RB_PCHK;
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_handle_next = res_handle_reg;
                    out_slot_next   = res_slot_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT_CLR;
            bank_reg      <= 1'b0;
            live_reg      <= '0;
            tomb_reg      <= '0;
            max_reg       <= htlp_pkg::MAX_RESET;
            n_reg         <= '0;
            rb_idx_reg    <= '0;
            rb_mode_reg   <= 1'b0;
            h_cnt_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            live_reg      <= live_next;
            tomb_reg      <= tomb_next;
            max_reg       <= max_next;
            n_reg         <= n_next;
            rb_idx_reg    <= rb_idx_next;
            rb_mode_reg   <= rb_mode_next;
            h_cnt_reg     <= h_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        handle_reg     <= handle_next;
        target_reg     <= target_next;
        slot_reg       <= slot_next;
        tslot_reg      <= tslot_next;
        h_v_reg        <= h_v_next;
        h_acc_reg      <= h_acc_next;
        h_prod_reg     <= h_prod_next;
        src_key_reg    <= src_key_next;
        src_handle_reg <= src_handle_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
        out_slot_reg   <= out_slot_next;
    end

    // tombstones can never outnumber the slots of a bank
    a_tomb_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tomb_reg <= CW'(htlp_pkg::SLOT_COUNT))
        else $error("tombstone count out of range");

    // one op at a time: an accepted beat takes the block out of idle
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("beat accepted while an op is in flight");

    // a bank swap only happens at the end of a rebuild, which drops all tombstones
    a_swap_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_reg != $past(bank_reg)) |-> (tomb_reg == '0))
        else $error("bank swapped with tombstones left");

    // probe walk writes only for erase and insert
    a_probe_write: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg == S_PRB_CHK)) |->
        ((kind_reg == htlp_pkg::KIND_ERASE) || (kind_reg == htlp_pkg::KIND_INSERT)))
        else $error("table write from a read-only walk");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int IDLE_LIMIT = 100000;   // cycles with no beat on either channel
    localparam int POOL_SIZE  = 320;

    typedef struct packed {
        logic [htlp_pkg::KIND_W-1:0]   kind;
        logic [htlp_pkg::KEY_W-1:0]    key;
        logic [htlp_pkg::HANDLE_W-1:0] handle;
        logic [htlp_pkg::TARGET_W-1:0] target;
    } op_t;

    typedef struct packed {
        logic [htlp_pkg::STATUS_W-1:0]   status;
        logic [htlp_pkg::HANDLE_W-1:0]   handle;
        logic [htlp_pkg::SLOT_OUT_W-1:0] slot;
    } answer_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [htlp_pkg::CFG_W-1:0] cfg_wdata;

    htlp_in_if  req_if ();
    htlp_out_if rsp_if ();

    hash_table_linear_probe_tombstone_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the table: two banks, marks, live and tombstone counts
    // ------------------------------------------------------------------
    logic [htlp_pkg::KEY_W-1:0]    shadow_key  [htlp_pkg::BANK_DEPTH];
    logic [htlp_pkg::HANDLE_W-1:0] shadow_hdl  [htlp_pkg::BANK_DEPTH];
    logic [htlp_pkg::MARK_W-1:0]   shadow_mark [htlp_pkg::BANK_DEPTH];
    int                            cur_bank;
    int                            live_total;
    int                            tomb_total;
    int                            capacity;

    op_t     pending_ops[$];
    answer_t expected_answers[$];
    int      errors;

    // splitmix64 finalizer, low bits pick the home slot
    function automatic int home_of(logic [htlp_pkg::KEY_W-1:0] k);
        logic [htlp_pkg::KEY_W-1:0] v;
        v = k + htlp_pkg::HASH_C0;
        v = (v ^ (v >> htlp_pkg::HASH_S1)) * htlp_pkg::HASH_C1;
        v = (v ^ (v >> htlp_pkg::HASH_S2)) * htlp_pkg::HASH_C2;
        v = v ^ (v >> htlp_pkg::HASH_S3);
        return int'(v[htlp_pkg::SLOT_W-1:0]);
    endfunction

    // Copy live entries into the other bank, dropping tombstones
    function automatic void rebuild_into_spare();
        int src;
        int dst;
        int s;
        int n;
        src = cur_bank * htlp_pkg::SLOT_COUNT;
        dst = (1 - cur_bank) * htlp_pkg::SLOT_COUNT;
        for (int i = 0; i < htlp_pkg::SLOT_COUNT; i++)
            shadow_mark[dst + i] = htlp_pkg::MARK_EMPTY;
        for (int i = 0; i < htlp_pkg::SLOT_COUNT; i++)
        begin
            if (shadow_mark[src + i] == htlp_pkg::MARK_OCC)
            begin
                s = home_of(shadow_key[src + i]);
                n = 0;
                while (n < htlp_pkg::SLOT_COUNT && shadow_mark[dst + s] == htlp_pkg::MARK_OCC)
                begin
                    s = (s + 1) % htlp_pkg::SLOT_COUNT;
                    n++;
                end
                shadow_key[dst + s]  = shadow_key[src + i];
                shadow_hdl[dst + s]  = shadow_hdl[src + i];
                shadow_mark[dst + s] = htlp_pkg::MARK_OCC;
            end
        end
        cur_bank   = 1 - cur_bank;
        tomb_total = 0;
    endfunction

    // Walk for placement: hit=1 with the key's slot, else the first tombstone
    // or the terminating empty slot; SLOT_COUNT when neither exists.
    function automatic void placement_walk(logic [htlp_pkg::KEY_W-1:0] k,
                                           output bit hit, output int slot);
        int base;
        int s;
        int tomb;
        base = cur_bank * htlp_pkg::SLOT_COUNT;
        s    = home_of(k);
        tomb = htlp_pkg::SLOT_COUNT;
        hit  = 1'b0;
        slot = -1;
        for (int n = 0; n < htlp_pkg::SLOT_COUNT && slot < 0; n++)
        begin
            if (shadow_mark[base + s] == htlp_pkg::MARK_OCC && shadow_key[base + s] == k)
            begin
                hit  = 1'b1;
                slot = s;
            end
            else if (shadow_mark[base + s] == htlp_pkg::MARK_EMPTY)
                slot = (tomb == htlp_pkg::SLOT_COUNT) ? s : tomb;
            else
            begin
                if (shadow_mark[base + s] == htlp_pkg::MARK_TOMB
                    && tomb == htlp_pkg::SLOT_COUNT)
                    tomb = s;
                s = (s + 1) % htlp_pkg::SLOT_COUNT;
            end
        end
        if (slot < 0)
            slot = tomb;
    endfunction

    function automatic int locate_key(logic [htlp_pkg::KEY_W-1:0] k);
        int base;
        int s;
        base = cur_bank * htlp_pkg::SLOT_COUNT;
        s    = home_of(k);
        for (int n = 0; n < htlp_pkg::SLOT_COUNT; n++)
        begin
            if (shadow_mark[base + s] == htlp_pkg::MARK_EMPTY)
                return htlp_pkg::SLOT_COUNT;
            if (shadow_mark[base + s] == htlp_pkg::MARK_OCC && shadow_key[base + s] == k)
                return s;
            s = (s + 1) % htlp_pkg::SLOT_COUNT;
        end
        return htlp_pkg::SLOT_COUNT;
    endfunction

    function automatic void store_entry(int s, logic [htlp_pkg::KEY_W-1:0] k,
                                        logic [htlp_pkg::HANDLE_W-1:0] h);
        int a;
        a = cur_bank * htlp_pkg::SLOT_COUNT + s;
        if (shadow_mark[a] == htlp_pkg::MARK_TOMB && tomb_total > 0)
            tomb_total--;
        shadow_key[a]  = k;
        shadow_hdl[a]  = h;
        shadow_mark[a] = htlp_pkg::MARK_OCC;
        if (live_total < int'(htlp_pkg::LIVE_CAP))
            live_total++;
    endfunction

    function automatic answer_t apply_op(op_t op);
        answer_t r;
        bit      hit;
        int      s;
        r.status = htlp_pkg::ST_DONE;
        r.handle = '0;
        r.slot   = htlp_pkg::SLOT_NONE;
        case (op.kind)
            htlp_pkg::KIND_INSERT:
            begin
                if (op.key == '0)
                    r.status = htlp_pkg::ST_BAD_ID;
                else if (live_total >= capacity)
                    r.status = htlp_pkg::ST_FULL;
                else
                begin
                    if (tomb_total > htlp_pkg::REBUILD_LIMIT)
                        rebuild_into_spare();
                    placement_walk(op.key, hit, s);
                    if (hit)
                        r.status = htlp_pkg::ST_PRESENT;
                    else if (s == htlp_pkg::SLOT_COUNT)
                        r.status = htlp_pkg::ST_NO_SLOT;
                    else
                        store_entry(s, op.key, op.handle);
                end
            end
            htlp_pkg::KIND_FIND:
            begin
                if (op.key == '0)
                    r.status = htlp_pkg::ST_BAD_ID;
                else
                begin
                    s = locate_key(op.key);
                    if (s == htlp_pkg::SLOT_COUNT)
                        r.status = htlp_pkg::ST_ABSENT;
                    else
                        r.handle = shadow_hdl[cur_bank * htlp_pkg::SLOT_COUNT + s];
                end
            end
            htlp_pkg::KIND_ERASE:
            begin
                if (op.key == '0)
                    r.status = htlp_pkg::ST_BAD_ID;
                else
                begin
                    s = locate_key(op.key);
                    if (s == htlp_pkg::SLOT_COUNT)
                        r.status = htlp_pkg::ST_ABSENT;
                    else
                    begin
                        shadow_mark[cur_bank * htlp_pkg::SLOT_COUNT + s] = htlp_pkg::MARK_TOMB;
                        if (live_total > 0)
                            live_total--;
                        tomb_total++;
                    end
                end
            end
            htlp_pkg::KIND_RESERVE:
            begin
                // no id check, no write; may still trigger a rebuild
                if (tomb_total > htlp_pkg::REBUILD_LIMIT)
                    rebuild_into_spare();
                placement_walk(op.key, hit, s);
                if (hit)
                begin
                    r.status = htlp_pkg::ST_PRESENT;
                    r.slot   = htlp_pkg::SLOT_OUT_W'(s);
                end
                else if (s == htlp_pkg::SLOT_COUNT)
                    r.status = htlp_pkg::ST_NO_SLOT;
                else
                    r.slot = htlp_pkg::SLOT_OUT_W'(s);
            end
            htlp_pkg::KIND_COMMIT:
            begin
                if (int'(op.target) >= htlp_pkg::SLOT_COUNT)
                    r.status = htlp_pkg::ST_NO_SLOT;
                else
                    store_entry(int'(op.target), op.key, op.handle);
            end
            default: ;   // unused kinds answer done and touch nothing
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Request driver: changes at the falling edge, one item per beat
    // ------------------------------------------------------------------
    bit req_taken;     // set by the monitor when a request beat was accepted
    bit req_busy;
    int req_gap;
    bit req_calm;
    bit rsp_taken;
    int rsp_stall;
    bit rsp_calm;

    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 63) == 0)
            calm = ~calm;
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    always @(negedge clk)
    begin
        op_t op;
        bit  next_valid;
        if (rst_n)
        begin
            next_valid = req_if.valid;
            if (req_taken)
            begin
                req_busy   = 1'b0;
                next_valid = 1'b0;
                req_gap    = draw_wait(req_calm);
            end
            req_taken = 1'b0;
            if (!req_busy)
            begin
                if (req_gap > 0)
                    req_gap--;
                else if (pending_ops.size() > 0)
                begin
                    op = pending_ops.pop_front();
                    req_if.kind         <= op.kind;
                    req_if.order_key    <= op.key;
                    req_if.order_handle <= op.handle;
                    req_if.target_slot  <= op.target;
                    next_valid = 1'b1;
                    req_busy   = 1'b1;
                end
            end
            req_if.valid <= next_valid;

            // response back-pressure
            if (rsp_taken)
                rsp_stall = draw_wait(rsp_calm);
            rsp_taken = 1'b0;
            if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge, plus the watchdog
    // ------------------------------------------------------------------
    int idle_cycles;

    always @(posedge clk)
    begin
        answer_t want;
        op_t     seen;
        if (rst_n)
        begin
            // check the result beat first: it always belongs to an older item
            if (rsp_if.valid && rsp_if.ready)
            begin
                rsp_taken = 1'b1;
                if (expected_answers.size() == 0)
                    report_mismatch("unexpected result beat", 64'd1, 64'd0);
                else
                begin
                    want = expected_answers.pop_front();
                    if (rsp_if.status !== want.status)
                        report_mismatch("status", 64'(rsp_if.status), 64'(want.status));
                    if (rsp_if.found_handle !== want.handle)
                        report_mismatch("found_handle", 64'(rsp_if.found_handle),
                                        64'(want.handle));
                    if (rsp_if.slot_index !== want.slot)
                        report_mismatch("slot_index", 64'(rsp_if.slot_index), 64'(want.slot));
                end
            end
            if (req_if.valid && req_if.ready)
            begin
                req_taken = 1'b1;
                seen.kind   = req_if.kind;
                seen.key    = req_if.order_key;
                seen.handle = req_if.order_handle;
                seen.target = req_if.target_slot;
                expected_answers.push_back(apply_op(seen));
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("hash_table_linear_probe_tombstone_top regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    logic [htlp_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

    function automatic logic [htlp_pkg::KEY_W-1:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    function automatic op_t make_op(logic [htlp_pkg::KIND_W-1:0] k,
                                    logic [htlp_pkg::KEY_W-1:0] key,
                                    logic [htlp_pkg::HANDLE_W-1:0] h,
                                    logic [htlp_pkg::TARGET_W-1:0] t);
        op_t op;
        op.kind   = k;
        op.key    = key;
        op.handle = h;
        op.target = t;
        return op;
    endfunction

    // Mostly keys from a shared pool so finds and erases hit; some noise
    function automatic op_t random_op();
        int                          pick;
        int                          sel;
        logic [htlp_pkg::KEY_W-1:0]  key;
        logic [htlp_pkg::KIND_W-1:0] k;
        sel = $urandom_range(0, 99);
        if (sel < 3)
            key = '0;
        else if (sel < 10)
            key = rand_key();
        else
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        pick = $urandom_range(0, 99);
        if (pick < 36)
            k = htlp_pkg::KIND_INSERT;
        else if (pick < 56)
            k = htlp_pkg::KIND_FIND;
        else if (pick < 82)
            k = htlp_pkg::KIND_ERASE;
        else if (pick < 91)
            k = htlp_pkg::KIND_RESERVE;
        else if (pick < 98)
            k = htlp_pkg::KIND_COMMIT;
        else
            k = htlp_pkg::KIND_W'($urandom_range(5, 7));
        return make_op(k, key, $urandom(), htlp_pkg::TARGET_W'($urandom()));
    endfunction

    // Block is idle once every item is accepted and every result is back
    task automatic drain();
        while (pending_ops.size() > 0 || req_busy || expected_answers.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_capacity(int value);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= htlp_pkg::CFG_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        capacity = value;
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            pending_ops.push_back(random_op());
    endtask

    initial
    begin
        logic [htlp_pkg::KEY_W-1:0] ka;
        logic [htlp_pkg::KEY_W-1:0] kb;
        errors     = 0;
        cur_bank   = 0;
        live_total = 0;
        tomb_total = 0;
        capacity   = int'(htlp_pkg::MAX_RESET);
        for (int i = 0; i < htlp_pkg::BANK_DEPTH; i++)
            shadow_mark[i] = htlp_pkg::MARK_EMPTY;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = rand_key();
        key_pool[0] = '1;
        key_pool[1] = 64'd1;
        key_pool[2] = 64'h8000_0000_0000_0000;
        ka = key_pool[3];
        kb = key_pool[4];

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_if.valid        = 1'b0;
        req_if.kind         = '0;
        req_if.order_key    = '0;
        req_if.order_handle = '0;
        req_if.target_slot  = '0;
        rsp_if.ready        = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_capacity(512);

        // directed: id checks, duplicate, tombstone reuse, reserve, commit
        pending_ops.push_back(make_op(htlp_pkg::KIND_INSERT,  '0, 32'h1, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_INSERT,  ka, 32'hFFFF_FFFF, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_INSERT,  ka, 32'h0, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_FIND,    ka, '0, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_FIND,    '0, '0, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_FIND,    kb, '0, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_ERASE,   '0, '0, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_ERASE,   kb, '0, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_RESERVE, ka, '0, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_RESERVE, kb, '0, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_RESERVE, '0, '0, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_COMMIT,  '1, '1, '1));
        pending_ops.push_back(make_op(htlp_pkg::KIND_FIND,    '1, '0, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_COMMIT,  '0, 32'h5A5A_A5A5, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_INSERT,  64'd1, 32'h8000_0001, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_ERASE,   ka, '0, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_FIND,    ka, '0, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_ERASE,   ka, '0, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_RESERVE, ka, '0, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_INSERT,  ka, 32'h1234_5678, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_FIND,    ka, '0, '0));
        pending_ops.push_back(make_op(3'd5,                   ka, '1, '1));
        pending_ops.push_back(make_op(3'd6,                   '0, '0, '0));
        pending_ops.push_back(make_op(3'd7,                   '1, '1, '1));

        // zero capacity: every insert rejected
        set_capacity(0);
        pending_ops.push_back(make_op(htlp_pkg::KIND_INSERT, kb, 32'h7, '0));
        pending_ops.push_back(make_op(htlp_pkg::KIND_INSERT, '1, 32'h7, '0));
        queue_random(40);

        set_capacity(1);
        queue_random(40);

        // widest capacity: erases pile up tombstones and rebuild
        set_capacity(1023);
        queue_random(700);

        set_capacity($urandom_range(200, 600));
        queue_random(400);

        set_capacity(512);
        queue_random(300);

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("hash_table_linear_probe_tombstone_top regression: pass");
        else
            $display("hash_table_linear_probe_tombstone_top regression: fail");
        $finish;
    end

endmodule
